>>> sv/fptc_pkg.sv
// ============================================================================
// fptc_pkg
// Shared types, codes and constants of the fan power and throttle controller.
// ============================================================================
package fptc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SLOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FAST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TMO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TMO     = 3'd7;

    // Key event codes
    localparam logic [1:0] KEY_NONE   = 2'd0;
    localparam logic [1:0] KEY_SHORT  = 2'd1;
    localparam logic [1:0] KEY_LONG   = 2'd2;
    localparam logic [1:0] KEY_DOUBLE = 2'd3;

    // Reported power mode codes
    localparam logic [1:0] PM_SLEEP    = 2'd0;
    localparam logic [1:0] PM_WAKING   = 2'd1;
    localparam logic [1:0] PM_RUNNING  = 2'd2;
    localparam logic [1:0] PM_CHARGING = 2'd3;

    // LED colors (red, green, blue)
    localparam logic [2:0] LED_OFF   = 3'd0;
    localparam logic [2:0] LED_BLUE  = 3'd1;
    localparam logic [2:0] LED_GREEN = 3'd2;
    localparam logic [2:0] LED_RED   = 3'd4;
    localparam logic [2:0] LED_WHITE = 3'd7;

    localparam logic [15:0] IDLE_TIMEOUT = 16'd3000;
    localparam logic [15:0] SLOW_PHASE   = 16'd500;

    // x/10 == (x * 6554) >> 16 for x below 16389
    localparam logic [12:0] RECIP_TEN   = 13'd6554;
    localparam int          RECIP_SHIFT = 16;

    typedef struct packed {
        logic [7:0]  level_one_duty;
        logic [7:0]  level_two_duty;
        logic [7:0]  level_three_duty;
        logic [7:0]  ramp_slow;
        logic [7:0]  ramp_fast;
        logic [7:0]  start_duty;
        logic [15:0] stall_timeout;
        logic [15:0] run_timeout;
    } fptc_cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  key_event;
        logic        charger_absent;
        logic        battery_low;
        logic        motor_running;
        logic        desync_seen;
        logic [15:0] phase_period;
    } fptc_req_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       duty_write;
        logic       stop_motor;
        logic       start_motor;
        logic       driver_power;
        logic [1:0] throttle_step;
        logic [1:0] power_mode;
        logic [2:0] led_rgb;
        logic       lowbat_alert;
    } fptc_rsp_t;

endpackage

>>> sv/fptc_if.sv
// ============================================================================
// fptc_req_if / fptc_rsp_if
// Valid/ready channels for requests and results of the throttle controller.
// ============================================================================
interface fptc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [1:0]  key_event;
    logic        charger_absent;
    logic        battery_low;
    logic        motor_running;
    logic        desync_seen;
    logic [15:0] phase_period;

    modport source (
        output valid, req_type, key_event, charger_absent, battery_low,
               motor_running, desync_seen, phase_period,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_event, charger_absent, battery_low,
               motor_running, desync_seen, phase_period,
        output ready
    );
endinterface

interface fptc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       duty_write;
    logic       stop_motor;
    logic       start_motor;
    logic       driver_power;
    logic [1:0] throttle_step;
    logic [1:0] power_mode;
    logic [2:0] led_rgb;
    logic       lowbat_alert;

    modport source (
        output valid, duty, duty_write, stop_motor, start_motor, driver_power,
               throttle_step, power_mode, led_rgb, lowbat_alert,
        input  ready
    );
    modport sink (
        input  valid, duty, duty_write, stop_motor, start_motor, driver_power,
               throttle_step, power_mode, led_rgb, lowbat_alert,
        output ready
    );
endinterface

>>> sv/fptc_cfg_regs.sv
// ============================================================================
// fptc_cfg_regs
// Configuration register file, write-only, reset to the default profile.
// ============================================================================
module fptc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fptc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fptc_pkg::CFG_DATA_W-1:0] cfg_data,
    output fptc_pkg::fptc_cfg_t             cfg
);
    import fptc_pkg::*;

    fptc_cfg_t cfg_reg;
    fptc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LEVEL_ONE:   cfg_next.level_one_duty   = cfg_data[7:0];
                CFG_LEVEL_TWO:   cfg_next.level_two_duty   = cfg_data[7:0];
                CFG_LEVEL_THREE: cfg_next.level_three_duty = cfg_data[7:0];
                CFG_RAMP_SLOW:   cfg_next.ramp_slow        = cfg_data[7:0];
                CFG_RAMP_FAST:   cfg_next.ramp_fast        = cfg_data[7:0];
                CFG_START_DUTY:  cfg_next.start_duty       = cfg_data[7:0];
                CFG_STALL_TMO:   cfg_next.stall_timeout    = cfg_data;
                CFG_RUN_TMO:     cfg_next.run_timeout      = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_one_duty   <= 8'd80;
            cfg_reg.level_two_duty   <= 8'd160;
            cfg_reg.level_three_duty <= 8'd255;
            cfg_reg.ramp_slow        <= 8'd2;
            cfg_reg.ramp_fast        <= 8'd8;
            cfg_reg.start_duty       <= 8'd40;
            cfg_reg.stall_timeout    <= 16'd200;
            cfg_reg.run_timeout      <= 16'd30000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/fptc_duty.sv
// ============================================================================
// fptc_duty
// Closed-loop duty update: desync halving, 9:1 smoothing, ramp limit.
// ============================================================================
module fptc_duty (
    input  fptc_pkg::fptc_cfg_t cfg,
    input  logic [1:0]          throttle_idx,
    input  logic [7:0]          duty_cur,
    input  logic [7:0]          duty_last,
    input  logic                desync_seen,
    input  logic [15:0]         phase_period,
    output logic [7:0]          duty_new
);
    import fptc_pkg::*;

    logic [7:0]        target;
    logic [7:0]        duty_base;
    logic [11:0]       blend;
    logic [24:0]       blend_prod;
    logic [7:0]        smoothed;
    logic [7:0]        ramp;
    logic signed [9:0] delta;
    logic signed [9:0] ramp_s;

    always_comb
    begin
        case (throttle_idx)
            2'd1:    target = cfg.level_one_duty;
            2'd2:    target = cfg.level_two_duty;
            2'd3:    target = cfg.level_three_duty;
            default: target = 8'd0;
        endcase
    end

    assign duty_base  = desync_seen ? {1'b0, duty_cur[7:1]} : duty_cur;
    // 9*d + target, at most 2550
    assign blend      = {1'b0, duty_base, 3'b000} + {4'b0, duty_base} + {4'b0, target};
    assign blend_prod = 25'(blend) * 25'(RECIP_TEN);
    assign smoothed   = blend_prod[RECIP_SHIFT+7:RECIP_SHIFT];

    assign ramp   = (phase_period > SLOW_PHASE) ? cfg.ramp_slow : cfg.ramp_fast;
    assign delta  = $signed({2'b00, smoothed}) - $signed({2'b00, duty_last});
    assign ramp_s = $signed({2'b00, ramp});

    always_comb
    begin
        if (delta > ramp_s)
            duty_new = 8'(duty_last + ramp);
        else if (delta < -ramp_s)
            duty_new = 8'(duty_last - ramp);
        else
            duty_new = smoothed;
    end

endmodule

>>> sv/fan_power_throttle_controller_core.sv
// ============================================================================
// fan_power_throttle_controller_core
// Power mode, throttle and duty controller driven by tick and key requests.
// ============================================================================
// Flow: a request is captured in the input register at accept; its result
//   is loaded into the result register when the held request advances and
//   is taken from there. A stalled result holds the input register.
// Throughput: one request per cycle while results are taken (single-pass update).
// Reset: asynchronous active-low; mode goes to sleep, counters, duty, LED
//   and driver power clear, configuration loads its default profile.
module fan_power_throttle_controller_core #(
    parameter int THROTTLE_STEPS = 4   // 2..4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fptc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fptc_pkg::CFG_DATA_W-1:0] cfg_data,
    fptc_req_if.sink                        req,
    fptc_rsp_if.source                      rsp
);
    import fptc_pkg::*;

    localparam logic [2:0] STEPS = 3'(THROTTLE_STEPS);

    typedef struct packed {
        logic sleep;
        logic waking;
        logic running;
        logic charging;
        logic batlow;
    } mode_t;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    fptc_cfg_t cfg;

    fptc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake: input register -> single-pass update -> result register
    // ------------------------------------------------------------------
    logic      in_v_reg, in_v_next;
    fptc_req_t in_reg;
    logic      rsp_v_reg, rsp_v_next;
    fptc_rsp_t rsp_reg, rsp_next;
    logic      req_fire;
    logic      advance;

    // a held request moves on whenever the result slot is free or draining
    assign advance    = in_v_reg && (!rsp_v_reg || rsp.ready);
    assign req.ready  = !in_v_reg || advance;
    assign req_fire   = req.valid && req.ready;
    assign in_v_next  = req_fire || (in_v_reg && !advance);
    assign rsp_v_next = advance || (rsp_v_reg && !rsp.ready);

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    mode_t       mode_reg, mode_next;
    logic [1:0]  idx_reg, idx_next;
    logic        start_pend_reg, start_pend_next;
    logic [7:0]  duty_reg, duty_next;
    logic [7:0]  last_duty_reg, last_duty_next;
    logic [15:0] stall_cnt_reg, stall_cnt_next;
    logic [15:0] auto_off_reg, auto_off_next;
    logic        drv_on_reg, drv_on_next;
    logic [2:0]  led_reg, led_next;
    logic [1:0]  led_shown_reg, led_shown_next;
    logic        led_ok_reg, led_ok_next;

    logic [7:0]  duty_run;

    fptc_duty u_duty (
        .cfg          (cfg),
        .throttle_idx (idx_reg),
        .duty_cur     (duty_reg),
        .duty_last    (last_duty_reg),
        .desync_seen  (in_reg.desync_seen),
        .phase_period (in_reg.phase_period),
        .duty_new     (duty_run)
    );

    // Next state follows the request semantics in order; every branch is
    // a few gates except the duty path, which lives in fptc_duty.
    always_comb
    begin
        logic        stop;
        logic        start;
        logic        wrote;
        logic        alert;
        logic        show;
        logic [2:0]  idx_inc;
        logic [15:0] auto_limit;

        mode_next       = mode_reg;
        idx_next        = idx_reg;
        start_pend_next = start_pend_reg;
        duty_next       = duty_reg;
        last_duty_next  = last_duty_reg;
        stall_cnt_next  = stall_cnt_reg;
        auto_off_next   = auto_off_reg;
        drv_on_next     = drv_on_reg;
        led_next        = led_reg;
        led_shown_next  = led_shown_reg;
        led_ok_next     = led_ok_reg;
        stop            = 1'b0;
        start           = 1'b0;
        wrote           = 1'b0;
        alert           = 1'b0;
        show            = 1'b0;
        idx_inc         = {1'b0, idx_reg} + 3'd1;
        auto_limit      = IDLE_TIMEOUT;

        if (in_reg.req_type)
        begin
            // key request
            if (in_reg.key_event != KEY_NONE)
            begin
                auto_off_next = '0;
                case (in_reg.key_event)
                    KEY_SHORT:
                    begin
                        if (!(mode_reg.sleep || mode_reg.waking || mode_reg.batlow))
                        begin
                            if (idx_inc >= STEPS)
                            begin
                                idx_next = '0;
                                stop     = 1'b1;
                            end
                            else
                            begin
                                idx_next = idx_inc[1:0];
                            end
                            if (idx_next == 2'd1)
                                start_pend_next = 1'b1;
                        end
                    end
                    KEY_LONG:
                    begin
                        if (mode_reg.sleep)
                        begin
                            mode_next.waking = 1'b1;
                        end
                        else
                        begin
                            stop              = 1'b1;
                            idx_next          = '0;
                            mode_next.running = 1'b0;
                            mode_next.sleep   = 1'b1;
                        end
                    end
                    default:
                    begin
                        // double press
                        if (!mode_reg.sleep)
                        begin
                            stop     = 1'b1;
                            idx_next = '0;
                        end
                    end
                endcase
            end
        end
        else
        begin
            // tick request: wake completion
            if (mode_next.waking)
            begin
                mode_next.waking = 1'b0;
                if (!in_reg.charger_absent)
                begin
                    stop               = 1'b1;
                    idx_next           = '0;
                    drv_on_next        = 1'b0;
                    mode_next.running  = 1'b0;
                    mode_next.charging = 1'b1;
                    mode_next.sleep    = 1'b1;
                end
                else
                begin
                    drv_on_next        = 1'b1;
                    mode_next.sleep    = 1'b0;
                    mode_next.charging = 1'b0;
                    mode_next.running  = 1'b1;
                    led_next           = LED_RED;
                end
            end
            // charger plugged in while running
            if (mode_next.running && !in_reg.charger_absent)
            begin
                stop               = 1'b1;
                idx_next           = '0;
                drv_on_next        = 1'b0;
                mode_next.running  = 1'b0;
                mode_next.charging = 1'b1;
                mode_next.sleep    = 1'b1;
            end
            mode_next.batlow = in_reg.battery_low;
            // low battery shutdown
            if (mode_next.batlow && mode_next.running)
            begin
                stop              = 1'b1;
                idx_next          = '0;
                alert             = 1'b1;
                led_next          = LED_OFF;
                mode_next.running = 1'b0;
                mode_next.sleep   = 1'b1;
            end

            if (mode_next.sleep)
            begin
                if (in_reg.motor_running || start_pend_reg)
                begin
                    stop            = 1'b1;
                    start_pend_next = 1'b0;
                end
                idx_next    = '0;
                led_next    = LED_OFF;
                drv_on_next = 1'b0;
            end
            else if (mode_next.running)
            begin
                if (in_reg.motor_running)
                begin
                    duty_next      = duty_run;
                    last_duty_next = duty_run;
                    wrote          = 1'b1;
                    stall_cnt_next = (in_reg.desync_seen ? 16'd0 : stall_cnt_reg) + 16'd1;
                    if (stall_cnt_next >= cfg.stall_timeout)
                    begin
                        stop     = 1'b1;
                        idx_next = '0;
                    end
                end
                else if (start_pend_reg)
                begin
                    start           = 1'b1;
                    start_pend_next = 1'b0;
                    stall_cnt_next  = '0;
                    last_duty_next  = cfg.start_duty;
                    duty_next       = cfg.start_duty;
                end

                // auto-off: idle limit at step zero, run limit otherwise
                auto_off_next = auto_off_reg + 16'd1;
                if (idx_next != 2'd0)
                    auto_limit = cfg.run_timeout;
                if (auto_off_next >= auto_limit)
                begin
                    auto_off_next     = '0;
                    stop              = 1'b1;
                    idx_next          = '0;
                    mode_next.running = 1'b0;
                    mode_next.sleep   = 1'b1;
                end
                show = 1'b1;
            end
        end

        // step indication, only refreshed when the step changes
        if (show && !(led_ok_reg && led_shown_reg == idx_next))
        begin
            led_ok_next    = 1'b1;
            led_shown_next = idx_next;
            case (idx_next)
                2'd0:    led_next = LED_RED;
                2'd1:    led_next = LED_GREEN;
                2'd2:    led_next = LED_BLUE;
                default: led_next = LED_WHITE;
            endcase
        end

        rsp_next.duty          = duty_next;
        rsp_next.duty_write    = wrote;
        rsp_next.stop_motor    = stop;
        rsp_next.start_motor   = start;
        rsp_next.driver_power  = drv_on_next;
        rsp_next.throttle_step = idx_next;
        rsp_next.led_rgb       = led_next;
        rsp_next.lowbat_alert  = alert;
        if (mode_next.waking)
            rsp_next.power_mode = PM_WAKING;
        else if (mode_next.charging && mode_next.sleep)
            rsp_next.power_mode = PM_CHARGING;
        else if (mode_next.running)
            rsp_next.power_mode = PM_RUNNING;
        else
            rsp_next.power_mode = PM_SLEEP;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg       <= 1'b0;
            rsp_v_reg      <= 1'b0;
            mode_reg       <= '{sleep: 1'b1, default: 1'b0};
            idx_reg        <= '0;
            start_pend_reg <= 1'b0;
            duty_reg       <= '0;
            last_duty_reg  <= '0;
            stall_cnt_reg  <= '0;
            auto_off_reg   <= '0;
            drv_on_reg     <= 1'b0;
            led_reg        <= LED_OFF;
            led_shown_reg  <= '0;
            led_ok_reg     <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            rsp_v_reg <= rsp_v_next;
            if (advance)
            begin
                mode_reg       <= mode_next;
                idx_reg        <= idx_next;
                start_pend_reg <= start_pend_next;
                duty_reg       <= duty_next;
                last_duty_reg  <= last_duty_next;
                stall_cnt_reg  <= stall_cnt_next;
                auto_off_reg   <= auto_off_next;
                drv_on_reg     <= drv_on_next;
                led_reg        <= led_next;
                led_shown_reg  <= led_shown_next;
                led_ok_reg     <= led_ok_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_reg.req_type       <= req.req_type;
            in_reg.key_event      <= req.key_event;
            in_reg.charger_absent <= req.charger_absent;
            in_reg.battery_low    <= req.battery_low;
            in_reg.motor_running  <= req.motor_running;
            in_reg.desync_seen    <= req.desync_seen;
            in_reg.phase_period   <= req.phase_period;
        end
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid         = rsp_v_reg;
    assign rsp.duty          = rsp_reg.duty;
    assign rsp.duty_write    = rsp_reg.duty_write;
    assign rsp.stop_motor    = rsp_reg.stop_motor;
    assign rsp.start_motor   = rsp_reg.start_motor;
    assign rsp.driver_power  = rsp_reg.driver_power;
    assign rsp.throttle_step = rsp_reg.throttle_step;
    assign rsp.power_mode    = rsp_reg.power_mode;
    assign rsp.led_rgb       = rsp_reg.led_rgb;
    assign rsp.lowbat_alert  = rsp_reg.lowbat_alert;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // sleep and running are always complementary
    a_sleep_run: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg.sleep != mode_reg.running)
        else $error("sleep and running flags out of step");

    // waking only ever starts from sleep
    a_wake_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg.waking |-> mode_reg.sleep)
        else $error("waking without sleep");

    // throttle index stays within the configured step count
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, idx_reg} < STEPS)
        else $error("throttle index out of range");

    // a low battery alert always comes with a motor stop
    a_alert_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_v_reg && rsp_reg.lowbat_alert) |-> rsp_reg.stop_motor)
        else $error("low battery alert without stop");

endmodule

>>> bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the fan power and throttle controller core.
// Sends tick and key requests with random pacing on both channels. A
// behavioral copy of the controller predicts each status result, and every
// result is compared field by field. Runs several register profiles.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import fptc_pkg::*;

    localparam int STEPS       = 4;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int MAX_PRINTS  = 100;

    // request kinds carried in req_type
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fptc_req_if req_ch();
    fptc_rsp_if rsp_ch();

    fan_power_throttle_controller_core #(
        .THROTTLE_STEPS (STEPS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------------
    fptc_rsp_t status_due_q[$];     // predicted status, oldest first
    bit        pacing_on;           // random gaps/stalls on both channels
    int        error_count;
    int        requests_sent;
    int        results_checked;
    int        profiles_run;
    int        writes_due;
    int        starts_due;
    int        stops_due;
    int        alerts_due;
    int        cycle_count;

    // ------------------------------------------------------------------------
    // Controller shadow state (what the block should hold)
    // ------------------------------------------------------------------------
    fptc_cfg_t   cfg_shadow;
    logic        fl_sleep;
    logic        fl_waking;
    logic        fl_running;
    logic        fl_charging;
    logic        fl_batlow;
    logic [1:0]  step_q;
    logic        start_pending_q;
    logic [7:0]  duty_q;
    logic [7:0]  last_duty_q;
    logic [15:0] stall_ticks;
    logic [15:0] idle_ticks;
    logic        drv_on_q;
    logic [2:0]  led_q;
    logic [1:0]  led_step_shown;
    logic        led_step_known;    // false until the LED has shown a step

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("watchdog: cycle limit reached, %0d results still pending",
                 status_due_q.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic fptc_cfg_t default_profile();
        fptc_cfg_t p;
        p.level_one_duty   = 8'd80;
        p.level_two_duty   = 8'd160;
        p.level_three_duty = 8'd255;
        p.ramp_slow        = 8'd2;
        p.ramp_fast        = 8'd8;
        p.start_duty       = 8'd40;
        p.stall_timeout    = 16'd200;
        p.run_timeout      = 16'd30000;
        return p;
    endfunction

    function automatic void reset_controller_shadow();
        cfg_shadow      = default_profile();
        fl_sleep        = 1'b1;
        fl_waking       = 1'b0;
        fl_running      = 1'b0;
        fl_charging     = 1'b0;
        fl_batlow       = 1'b0;
        step_q          = 2'd0;
        start_pending_q = 1'b0;
        duty_q          = 8'd0;
        last_duty_q     = 8'd0;
        stall_ticks     = 16'd0;
        idle_ticks      = 16'd0;
        drv_on_q        = 1'b0;
        led_q           = LED_OFF;
        led_step_shown  = 2'd0;
        led_step_known  = 1'b0;
    endfunction

    // charger sensed: stop, drop power and park in charging sleep
    function automatic void park_for_charging();
        step_q     = 2'd0;
        drv_on_q   = 1'b0;
        fl_running = 1'b0;
        fl_charging = 1'b1;
        fl_sleep   = 1'b1;
    endfunction

    function automatic logic [1:0] reported_mode();
        if (fl_waking)
            return PM_WAKING;
        if (fl_charging && fl_sleep)
            return PM_CHARGING;
        if (fl_running)
            return PM_RUNNING;
        return PM_SLEEP;
    endfunction

    // Applies one request to the shadow state and returns the status the
    // block must report for it.
    function automatic fptc_rsp_t advance_controller(fptc_req_t r);
        fptc_rsp_t   s;
        logic        stop;
        logic        start;
        logic        wrote;
        logic        alert;
        int          next_step;
        int unsigned blend;
        logic [7:0]  target;
        logic [7:0]  ramp;
        int          delta;

        stop  = 1'b0;
        start = 1'b0;
        wrote = 1'b0;
        alert = 1'b0;

        if (r.req_type == REQ_KEY)
        begin
            if (r.key_event != KEY_NONE)
            begin
                idle_ticks = 16'd0;
                case (r.key_event)
                    KEY_SHORT:
                    begin
                        // ignored while asleep, waking or on a low battery
                        if (!(fl_sleep || fl_waking) && !fl_batlow)
                        begin
                            next_step = int'(step_q) + 1;
                            if (next_step >= STEPS)
                            begin
                                next_step = 0;
                                stop      = 1'b1;
                            end
                            step_q = 2'(next_step);
                            if (step_q == 2'd1)
                                start_pending_q = 1'b1;
                        end
                    end
                    KEY_LONG:
                    begin
                        if (fl_sleep)
                            fl_waking = 1'b1;
                        else
                        begin
                            stop       = 1'b1;
                            step_q     = 2'd0;
                            fl_running = 1'b0;
                            fl_sleep   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!fl_sleep)
                        begin
                            stop   = 1'b1;
                            step_q = 2'd0;
                        end
                    end
                endcase
            end
        end
        else
        begin
            if (fl_waking)
            begin
                fl_waking = 1'b0;
                if (!r.charger_absent)
                begin
                    park_for_charging();
                    stop = 1'b1;
                end
                else
                begin
                    drv_on_q    = 1'b1;
                    fl_sleep    = 1'b0;
                    fl_charging = 1'b0;
                    fl_running  = 1'b1;
                    led_q       = LED_RED;
                end
            end
            if (fl_running && !r.charger_absent)
            begin
                park_for_charging();
                stop = 1'b1;
            end

            fl_batlow = r.battery_low;
            if (fl_batlow && fl_running)
            begin
                stop       = 1'b1;
                step_q     = 2'd0;
                alert      = 1'b1;
                led_q      = LED_OFF;
                fl_running = 1'b0;
                fl_sleep   = 1'b1;
            end

            if (fl_sleep)
            begin
                if (r.motor_running || start_pending_q)
                begin
                    stop            = 1'b1;
                    start_pending_q = 1'b0;
                end
                step_q   = 2'd0;
                led_q    = LED_OFF;
                drv_on_q = 1'b0;
            end
            else if (fl_running)
            begin
                if (r.motor_running)
                begin
                    // closed loop: halve on desync, smooth, then ramp limit
                    if (r.desync_seen)
                    begin
                        duty_q      = duty_q >> 1;
                        stall_ticks = 16'd0;
                    end
                    case (step_q)
                        2'd1:    target = cfg_shadow.level_one_duty;
                        2'd2:    target = cfg_shadow.level_two_duty;
                        2'd3:    target = cfg_shadow.level_three_duty;
                        default: target = 8'd0;
                    endcase
                    blend  = (int'(duty_q) * 9 + int'(target)) / 10;
                    duty_q = 8'(blend);
                    ramp   = (r.phase_period > SLOW_PHASE) ? cfg_shadow.ramp_slow
                                                           : cfg_shadow.ramp_fast;
                    delta  = int'(duty_q) - int'(last_duty_q);
                    if (delta > int'(ramp))
                        duty_q = last_duty_q + ramp;
                    else if (delta < -int'(ramp))
                        duty_q = last_duty_q - ramp;
                    last_duty_q = duty_q;

                    wrote       = 1'b1;
                    stall_ticks = stall_ticks + 16'd1;
                    if (stall_ticks >= cfg_shadow.stall_timeout)
                    begin
                        stop   = 1'b1;
                        step_q = 2'd0;
                    end
                end
                else if (start_pending_q)
                begin
                    // open loop start loads the start duty, no write
                    start           = 1'b1;
                    start_pending_q = 1'b0;
                    stall_ticks     = 16'd0;
                    last_duty_q     = cfg_shadow.start_duty;
                    duty_q          = cfg_shadow.start_duty;
                end

                idle_ticks = idle_ticks + 16'd1;
                if (idle_ticks >= ((step_q == 2'd0) ? IDLE_TIMEOUT
                                                    : cfg_shadow.run_timeout))
                begin
                    idle_ticks = 16'd0;
                    stop       = 1'b1;
                    step_q     = 2'd0;
                    fl_running = 1'b0;
                    fl_sleep   = 1'b1;
                end

                // LED follows the step, but only when the step changes
                if (!(led_step_known && led_step_shown == step_q))
                begin
                    led_step_known = 1'b1;
                    led_step_shown = step_q;
                    case (step_q)
                        2'd0:    led_q = LED_RED;
                        2'd1:    led_q = LED_GREEN;
                        2'd2:    led_q = LED_BLUE;
                        default: led_q = LED_WHITE;
                    endcase
                end
            end
        end

        s.duty          = duty_q;
        s.duty_write    = wrote;
        s.stop_motor    = stop;
        s.start_motor   = start;
        s.driver_power  = drv_on_q;
        s.throttle_step = step_q;
        s.power_mode    = reported_mode();
        s.led_rgb       = led_q;
        s.lowbat_alert  = alert;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at result %0d: %s", results_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    initial
    begin : status_monitor
        fptc_rsp_t got;
        fptc_rsp_t want;
        int        stall;

        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pacing_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (rsp_ch.valid !== 1'b1)
                @(posedge clk);

            got.duty          = rsp_ch.duty;
            got.duty_write    = rsp_ch.duty_write;
            got.stop_motor    = rsp_ch.stop_motor;
            got.start_motor   = rsp_ch.start_motor;
            got.driver_power  = rsp_ch.driver_power;
            got.throttle_step = rsp_ch.throttle_step;
            got.power_mode    = rsp_ch.power_mode;
            got.led_rgb       = rsp_ch.led_rgb;
            got.lowbat_alert  = rsp_ch.lowbat_alert;

            if (status_due_q.size() == 0)
                report_mismatch("status result with no request pending");
            else
            begin
                want = status_due_q.pop_front();
                check_field("duty", got.duty, want.duty);
                check_field("duty_write", 8'(got.duty_write), 8'(want.duty_write));
                check_field("stop_motor", 8'(got.stop_motor), 8'(want.stop_motor));
                check_field("start_motor", 8'(got.start_motor), 8'(want.start_motor));
                check_field("driver_power", 8'(got.driver_power), 8'(want.driver_power));
                check_field("throttle_step", 8'(got.throttle_step),
                            8'(want.throttle_step));
                check_field("power_mode", 8'(got.power_mode), 8'(want.power_mode));
                check_field("led_rgb", 8'(got.led_rgb), 8'(want.led_rgb));
                check_field("lowbat_alert", 8'(got.lowbat_alert), 8'(want.lowbat_alert));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------
    // Called at a rising edge; returns at the edge the request is taken.
    // valid stays high on return so back-to-back requests need no toggle.
    task automatic send_request(input fptc_req_t r);
        int        gap;
        fptc_rsp_t due;

        gap = pacing_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= r.req_type;
        req_ch.key_event      <= r.key_event;
        req_ch.charger_absent <= r.charger_absent;
        req_ch.battery_low    <= r.battery_low;
        req_ch.motor_running  <= r.motor_running;
        req_ch.desync_seen    <= r.desync_seen;
        req_ch.phase_period   <= r.phase_period;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);

        due = advance_controller(r);
        status_due_q.push_back(due);
        requests_sent++;
        writes_due += int'(due.duty_write);
        starts_due += int'(due.start_motor);
        stops_due  += int'(due.stop_motor);
        alerts_due += int'(due.lowbat_alert);
    endtask

    // Drop valid and wait for the block to go quiet before touching registers.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_LEVEL_ONE:   cfg_shadow.level_one_duty   = data[7:0];
            CFG_LEVEL_TWO:   cfg_shadow.level_two_duty   = data[7:0];
            CFG_LEVEL_THREE: cfg_shadow.level_three_duty = data[7:0];
            CFG_RAMP_SLOW:   cfg_shadow.ramp_slow        = data[7:0];
            CFG_RAMP_FAST:   cfg_shadow.ramp_fast        = data[7:0];
            CFG_START_DUTY:  cfg_shadow.start_duty       = data[7:0];
            CFG_STALL_TMO:   cfg_shadow.stall_timeout    = data;
            default:         cfg_shadow.run_timeout      = data;
        endcase
    endtask

    // 8-bit registers get junk in the upper byte; only the low byte counts.
    task automatic program_profile(input fptc_cfg_t p);
        write_reg(CFG_LEVEL_ONE,   {8'($urandom()), p.level_one_duty});
        write_reg(CFG_LEVEL_TWO,   {8'($urandom()), p.level_two_duty});
        write_reg(CFG_LEVEL_THREE, {8'($urandom()), p.level_three_duty});
        write_reg(CFG_RAMP_SLOW,   {8'($urandom()), p.ramp_slow});
        write_reg(CFG_RAMP_FAST,   {8'($urandom()), p.ramp_fast});
        write_reg(CFG_START_DUTY,  {8'($urandom()), p.start_duty});
        write_reg(CFG_STALL_TMO,   p.stall_timeout);
        write_reg(CFG_RUN_TMO,     p.run_timeout);
        cfg_wr_en <= 1'b0;
        profiles_run++;
    endtask

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    // fields a tick ignores (key_event) are filled with noise
    function automatic fptc_req_t tick_req(logic absent, logic low, logic spinning,
                                           logic desync, logic [15:0] period);
        fptc_req_t r;
        r.req_type       = REQ_TICK;
        r.key_event      = 2'($urandom());
        r.charger_absent = absent;
        r.battery_low    = low;
        r.motor_running  = spinning;
        r.desync_seen    = desync;
        r.phase_period   = period;
        return r;
    endfunction

    // fields a key event ignores are filled with noise
    function automatic fptc_req_t key_req(logic [1:0] k);
        fptc_req_t r;
        r.req_type       = REQ_KEY;
        r.key_event      = k;
        r.charger_absent = 1'($urandom());
        r.battery_low    = 1'($urandom());
        r.motor_running  = 1'($urandom());
        r.desync_seen    = 1'($urandom());
        r.phase_period   = 16'($urandom());
        return r;
    endfunction

    // phase period clustered around the slow/fast ramp threshold
    function automatic logic [15:0] random_period();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom());
            1:       return 16'($urandom_range(498, 503));
            2:       return 16'($urandom_range(0, 500));
            default: return 16'($urandom_range(501, 65535));
        endcase
    endfunction

    // Mostly well-formed use: wake when asleep, then ticks with the motor
    // spinning and occasional presses; charger, low battery and desync rare.
    function automatic fptc_req_t random_request();
        int roll;
        int pick;

        roll = $urandom_range(0, 99);
        if (fl_sleep && !fl_waking && roll < 50)
            return key_req(KEY_LONG);
        if (roll < 25)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                return key_req(KEY_SHORT);
            if (pick < 78)
                return key_req(KEY_LONG);
            if (pick < 90)
                return key_req(KEY_DOUBLE);
            return key_req(KEY_NONE);
        end
        return tick_req($urandom_range(0, 99) >= 3,
                        $urandom_range(0, 99) < 3,
                        $urandom_range(0, 99) < 80,
                        $urandom_range(0, 99) < 10,
                        random_period());
    endfunction

    function automatic fptc_cfg_t random_profile();
        fptc_cfg_t p;
        p.level_one_duty   = 8'($urandom());
        p.level_two_duty   = 8'($urandom());
        p.level_three_duty = 8'($urandom());
        p.ramp_slow        = 8'($urandom_range(0, 12));
        p.ramp_fast        = 8'($urandom_range(0, 60));
        p.start_duty       = 8'($urandom());
        p.stall_timeout    = 16'($urandom_range(1, 400));
        p.run_timeout      = 16'($urandom_range(5, 800));
        return p;
    endfunction

    task automatic random_traffic(input int count);
        for (int k = 0; k < count; k++)
        begin
            // pacing redrawn in chunks so some stretches run back to back
            if (k % 40 == 0)
                pacing_on = ($urandom_range(0, 3) != 0);
            send_request(random_request());
        end
        pacing_on = 1'b1;
    endtask

    // From any state: into sleep if needed, then wake with no charger.
    task automatic wake_up();
        if (!fl_sleep)
            send_request(key_req(KEY_LONG));
        send_request(key_req(KEY_LONG));
        send_request(tick_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Walk through every key, the charger and battery paths, the start and
    // the ramps, with reset register values.
    task automatic test_directed_walk();
        send_request(key_req(KEY_NONE));                             // status only
        send_request(tick_req(1'b1, 1'b0, 1'b1, 1'b0, 16'd0));       // stop in sleep
        send_request(key_req(KEY_SHORT));                            // ignored asleep
        send_request(key_req(KEY_DOUBLE));                           // ignored asleep
        send_request(key_req(KEY_LONG));                             // waking
        send_request(tick_req(1'b0, 1'b0, 1'b0, 1'b0, 16'd0));       // charger in
        send_request(key_req(KEY_LONG));
        send_request(tick_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0));       // running
        send_request(key_req(KEY_SHORT));                            // step one
        send_request(tick_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0));       // open loop start
        send_request(tick_req(1'b1, 1'b0, 1'b1, 1'b0, 16'd0));       // fast ramp
        send_request(tick_req(1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF));    // slow ramp
        send_request(tick_req(1'b1, 1'b0, 1'b1, 1'b1, 16'd501));     // desync halves
        send_request(tick_req(1'b1, 1'b0, 1'b1, 1'b0, 16'd500));
        send_request(key_req(KEY_SHORT));                            // step two
        send_request(tick_req(1'b1, 1'b0, 1'b1, 1'b0, 16'd100));
        send_request(key_req(KEY_SHORT));                            // step three
        send_request(tick_req(1'b1, 1'b0, 1'b1, 1'b0, 16'd100));
        send_request(key_req(KEY_SHORT));                            // wraps to zero
        send_request(key_req(KEY_DOUBLE));                           // stop while running
        send_request(tick_req(1'b0, 1'b0, 1'b1, 1'b0, 16'd0));       // charger while running
        wake_up();
        send_request(tick_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd0));       // low battery cutoff
        wake_up();
        send_request(key_req(KEY_LONG));                             // off while running
    endtask

    // Register profiles: reset values, all zero (timeouts fire every tick),
    // all ones, minimum timeouts, then random settings.
    task automatic test_config_profiles();
        fptc_cfg_t p;

        settle();
        program_profile(default_profile());
        random_traffic(200);

        settle();
        program_profile('0);
        random_traffic(100);

        settle();
        program_profile('1);
        random_traffic(150);

        settle();
        p               = random_profile();
        p.ramp_slow     = 8'd1;
        p.ramp_fast     = 8'd1;
        p.stall_timeout = 16'd1;
        p.run_timeout   = 16'd1;
        program_profile(p);
        random_traffic(100);

        repeat (5)
        begin
            settle();
            program_profile(random_profile());
            random_traffic(150);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        error_count     = 0;
        requests_sent   = 0;
        results_checked = 0;
        profiles_run    = 0;
        writes_due      = 0;
        starts_due      = 0;
        stops_due       = 0;
        alerts_due      = 0;
        pacing_on       = 1'b1;
        reset_controller_shadow();

        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= CFG_LEVEL_ONE;
        cfg_data              <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_TICK;
        req_ch.key_event      <= KEY_NONE;
        req_ch.charger_absent <= 1'b1;
        req_ch.battery_low    <= 1'b0;
        req_ch.motor_running  <= 1'b0;
        req_ch.desync_seen    <= 1'b0;
        req_ch.phase_period   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_walk();
        test_config_profiles();

        // drain: accepted requests pass through the input and result registers
        req_ch.valid <= 1'b0;
        for (int k = 0; k < 200 && status_due_q.size() != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (status_due_q.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      status_due_q.size()));

        $display("summary: %0d requests, %0d results checked, %0d register profiles, %0d cycles",
                 requests_sent, results_checked, profiles_run, cycle_count);
        $display("summary: %0d duty writes, %0d starts, %0d stops, %0d low battery alerts",
                 writes_due, starts_due, stops_due, alerts_due);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
sv/fptc_pkg.sv
sv/fptc_if.sv
sv/fptc_cfg_regs.sv
sv/fptc_duty.sv
sv/fan_power_throttle_controller_core.sv
bench/testbench.sv
